### src/npo_pkg.sv
package npo_pkg;

    localparam int ValueBitsDef = 32;
    localparam int FracBits     = 24;
    localparam int RootSteps    = 36;
    localparam int DivSteps     = 37;

    // update modes
    localparam logic [1:0] MODE_SGD  = 2'd0;
    localparam logic [1:0] MODE_MOM  = 2'd1;
    localparam logic [1:0] MODE_ADAM = 2'd2;

    // register indexes
    localparam logic [2:0] REG_MODE  = 3'd0;
    localparam logic [2:0] REG_LR    = 3'd1;
    localparam logic [2:0] REG_BETA1 = 3'd2;
    localparam logic [2:0] REG_BETA2 = 3'd3;
    localparam logic [2:0] REG_DECAY = 3'd4;
    localparam logic [2:0] REG_EPS   = 3'd5;
    localparam logic [2:0] REG_INV1  = 3'd6;
    localparam logic [2:0] REG_INV2  = 3'd7;

    typedef struct packed {
        logic signed [31:0] param_value;
        logic signed [31:0] grad_value;
        logic signed [31:0] velocity_in;
        logic        [30:0] second_moment_in;
        logic               is_bias;
    } t_in;

    typedef struct packed {
        logic signed [31:0] param_new;
        logic signed [31:0] velocity_out;
        logic        [30:0] second_moment_out;
    } t_out;

    typedef struct packed {
        logic [1:0]  mode;
        logic [24:0] lr;
        logic [24:0] b1;
        logic [24:0] b2;
        logic [24:0] lam;
        logic [24:0] eps;
        logic [39:0] inv1;
        logic [39:0] inv2;
    } t_cfg;

    // per-item values that ride along the cell chains
    typedef struct packed {
        logic signed [31:0] w;
        logic signed [31:0] g;
        logic signed [34:0] decay;
        logic signed [31:0] vnew;
        logic        [30:0] snew;
        logic               vc_neg;
        logic        [48:0] vc_mag;
    } t_carry;

    typedef struct packed {
        logic [47:0] x;
        logic [37:0] rem;
        logic [35:0] root;
    } t_root_st;

    typedef struct packed {
        logic [36:0] den;
        logic [36:0] rem;
        logic [36:0] quo;
        logic        ovf;
        logic        zero;
    } t_div_st;

endpackage

### src/neural_param_optimizer_update.sv
// throughput: one item per cycle while the skid entry is empty; the 36-cell square
//   root chain and the 37-cell divider chain each produce one root or quotient bit per cell
// a two-entry output register and skid stage let one more item in while a result waits
// reset: synchronous active-low, clears all valid bits and loads register defaults
module neural_param_optimizer_update import npo_pkg::*; #(
    parameter int VALUE_BITS = ValueBitsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out_data,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [39:0] i_cfg_data
);

    localparam int SatBits = (VALUE_BITS < 32) ? VALUE_BITS : 32;
    localparam logic signed [63:0] VMax = (64'sd1 <<< (SatBits - 1)) - 64'sd1;
    localparam logic signed [63:0] VMin = -(64'sd1 <<< (SatBits - 1));

    t_cfg r_cfg;
    logic en;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode <= MODE_SGD;
            r_cfg.lr   <= 25'd16777;
            r_cfg.b1   <= 25'd15099494;
            r_cfg.b2   <= 25'd16760439;
            r_cfg.lam  <= 25'd0;
            r_cfg.eps  <= 25'd1;
            r_cfg.inv1 <= 40'd167772160;
            r_cfg.inv2 <= 40'd16777216000;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_MODE:  r_cfg.mode <= i_cfg_data[1:0];
                REG_LR:    r_cfg.lr   <= i_cfg_data[24:0];
                REG_BETA1: r_cfg.b1   <= i_cfg_data[24:0];
                REG_BETA2: r_cfg.b2   <= i_cfg_data[24:0];
                REG_DECAY: r_cfg.lam  <= i_cfg_data[24:0];
                REG_EPS:   r_cfg.eps  <= i_cfg_data[24:0];
                REG_INV1:  r_cfg.inv1 <= i_cfg_data;
                REG_INV2:  r_cfg.inv2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // moment update and bias correction front end
    logic        f_valid;
    t_carry      f_carry;
    logic [47:0] f_x;

    npo_front #(.SAT_BITS(SatBits)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .i_cfg   (r_cfg),
        .o_valid (f_valid),
        .o_carry (f_carry),
        .o_x     (f_x)
    );

    // square root chain, most significant pair first
    logic     rv [0:RootSteps];
    t_carry   rc [0:RootSteps];
    t_root_st rs [0:RootSteps];

    assign rv[0] = f_valid;
    assign rc[0] = f_carry;
    assign rs[0] = '{x: f_x, rem: '0, root: '0};

    generate
        for (genvar i = 0; i < RootSteps; i++) begin : g_root
            npo_root_cell #(.K(RootSteps - 1 - i)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (en),
                .i_valid (rv[i]),
                .i_carry (rc[i]),
                .i_st    (rs[i]),
                .o_valid (rv[i + 1]),
                .o_carry (rc[i + 1]),
                .o_st    (rs[i + 1])
            );
        end
    endgenerate

    // divisor setup and quotient overflow check
    logic [36:0] den;
    t_div_st     n_d0;
    t_div_st     r_d0;
    t_carry      r_d0_c;
    logic        r_d0_v;

    assign den = 37'(rs[RootSteps].root) + 37'(r_cfg.eps);

    always_comb begin
        n_d0      = '0;
        n_d0.den  = den;
        n_d0.rem  = 37'(rc[RootSteps].vc_mag >> 13);
        n_d0.ovf  = 49'(rc[RootSteps].vc_mag >> 13) >= 49'(den);
        n_d0.zero = rc[RootSteps].vc_mag == '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d0_v <= 1'b0;
        end else if (en) begin
            r_d0_v <= rv[RootSteps];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d0   <= n_d0;
            r_d0_c <= rc[RootSteps];
        end
    end

    // divider chain, one quotient bit per cell
    logic    dv [0:DivSteps];
    t_carry  dc [0:DivSteps];
    t_div_st ds [0:DivSteps];

    assign dv[0] = r_d0_v;
    assign dc[0] = r_d0_c;
    assign ds[0] = r_d0;

    generate
        for (genvar i = 0; i < DivSteps; i++) begin : g_div
            npo_div_cell #(.K(DivSteps - 1 - i)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (en),
                .i_valid (dv[i]),
                .i_carry (dc[i]),
                .i_st    (ds[i]),
                .o_valid (dv[i + 1]),
                .o_carry (dc[i + 1]),
                .o_st    (ds[i + 1])
            );
        end
    endgenerate

    // step select and learning rate partial products
    logic        [36:0] qmag;
    logic signed [38:0] qs, step;
    t_carry             lc;
    logic               r_f1_v;
    logic signed [40:0] r_plh;
    logic signed [50:0] r_pll;
    logic signed [31:0] r_f1_w, r_f1_v_new;
    logic        [30:0] r_f1_s;

    assign lc   = dc[DivSteps];
    assign qmag = ds[DivSteps].zero ? '0 : (ds[DivSteps].ovf ? '1 : ds[DivSteps].quo);
    assign qs   = lc.vc_neg ? -$signed({2'b00, qmag}) : $signed({2'b00, qmag});

    always_comb begin
        case (r_cfg.mode)
            MODE_MOM:  step = 39'(lc.vnew) + 39'(lc.decay);
            MODE_ADAM: step = qs + 39'(lc.decay);
            default:   step = 39'(lc.g) + 39'(lc.decay);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
        end else if (en) begin
            r_f1_v <= dv[DivSteps];
        end
    end

    // high part of the step keeps its sign, low part is a plain fraction
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_plh      <= $signed({1'b0, r_cfg.lr}) * $signed(step[38:24]);
            r_pll      <= $signed({1'b0, r_cfg.lr}) * $signed({1'b0, step[23:0]});
            r_f1_w     <= lc.w;
            r_f1_v_new <= lc.vnew;
            r_f1_s     <= lc.snew;
        end
    end

    // final parameter and saturation
    logic signed [50:0] plr;
    logic signed [63:0] wsum, wsat;
    t_out               res;

    assign plr  = (r_pll + 51'sd8388608) >>> FracBits;
    assign wsum = 64'(r_f1_w) - (64'(r_plh) + 64'(plr));

    always_comb begin
        wsat = wsum;
        if (wsum > VMax) wsat = VMax;
        if (wsum < VMin) wsat = VMin;
        res.param_new         = wsat[31:0];
        res.velocity_out      = r_f1_v_new;
        res.second_moment_out = r_f1_s;
    end

    // output register with skid stage
    logic r_out_v, r_skid_v;
    t_out r_out, r_skid;
    logic take;

    assign en   = !r_skid_v;
    assign take = !r_out_v || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (take) begin
            r_out_v  <= r_skid_v || r_f1_v;
            r_skid_v <= 1'b0;
        end else if (r_f1_v && en) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= r_skid_v ? r_skid : res;
        end else if (r_f1_v && en) begin
            r_skid <= res;
        end
    end

    assign o_in_ready  = en;
    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    // skid entry only holds a result behind a waiting one
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry without output entry");

    // skid fills only when the output transfer stalled
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_out_v && !i_out_ready && r_f1_v))
        else $error("skid filled without stall");

    // pipeline frozen while skid is occupied
    a_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v && $past(r_skid_v) |-> $stable(r_f1_v))
        else $error("pipeline moved while skid full");

endmodule

### src/npo_front.sv
module npo_front import npo_pkg::*; #(
    parameter int SAT_BITS = ValueBitsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  t_in         i_data,
    input  t_cfg        i_cfg,
    output logic        o_valid,
    output t_carry      o_carry,
    output logic [47:0] o_x
);

    localparam logic signed [63:0] VMax = (64'sd1 <<< (SAT_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] VMin = -(64'sd1 <<< (SAT_BITS - 1));
    localparam logic signed [63:0] Half = 64'sd8388608;

    function automatic logic signed [31:0] sat_v(input logic signed [63:0] x);
        logic signed [63:0] y;
        begin
            y = x;
            if (x > VMax) y = VMax;
            if (x < VMin) y = VMin;
            return y[31:0];
        end
    endfunction

    function automatic logic [30:0] sat_m(input logic signed [63:0] x);
        logic signed [63:0] y;
        begin
            y = x;
            if (x > VMax) y = VMax;
            if (x < 64'sd0) y = 64'sd0;
            return y[30:0];
        end
    endfunction

    logic [5:0] r_valid;

    // stage 1: products
    logic signed [25:0] c1;
    logic        [31:0] ag;
    logic signed [57:0] r1_wd, r1_b1v, r1_c1g;
    logic        [63:0] r1_gg;
    logic        [55:0] r1_b2s;
    logic signed [31:0] r1_w, r1_g, r1_v;
    logic        [30:0] r1_s;
    logic               r1_bias;

    assign c1 = 26'sh1000000 - $signed({1'b0, i_cfg.b1});
    assign ag = i_data.grad_value[31] ? 32'(-i_data.grad_value) : 32'(i_data.grad_value);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_wd   <= i_data.param_value * $signed({1'b0, i_cfg.lam});
            r1_b1v  <= $signed({1'b0, i_cfg.b1}) * i_data.velocity_in;
            r1_c1g  <= c1 * i_data.grad_value;
            r1_gg   <= ag * ag;
            r1_b2s  <= i_cfg.b2 * i_data.second_moment_in;
            r1_w    <= i_data.param_value;
            r1_g    <= i_data.grad_value;
            r1_v    <= i_data.velocity_in;
            r1_s    <= i_data.second_moment_in;
            r1_bias <= i_data.is_bias;
        end
    end

    // stage 2: rounding, first moment, gradient square
    logic signed [58:0] vsum, vr;
    logic signed [57:0] dsum;
    logic        [64:0] gs;
    logic signed [31:0] n_vnew;
    logic signed [34:0] n_decay;
    logic signed [31:0] r2_w, r2_g, r2_vnew;
    logic signed [34:0] r2_decay;
    logic        [30:0] r2_s;
    logic        [39:0] r2_g2;
    logic        [55:0] r2_b2s;

    assign vsum    = 59'(r1_b1v) + 59'(r1_c1g);
    assign vr      = (vsum + 59'(Half)) >>> FracBits;
    assign dsum    = (r1_wd + 58'(Half)) >>> FracBits;
    assign gs      = 65'(r1_gg) + 65'd8388608;
    assign n_decay = r1_bias ? 35'sd0 : 35'(dsum);
    assign n_vnew  = (i_cfg.mode == MODE_MOM || i_cfg.mode == MODE_ADAM) ?
                     sat_v(64'(vr)) : r1_v;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_w     <= r1_w;
            r2_g     <= r1_g;
            r2_vnew  <= n_vnew;
            r2_decay <= n_decay;
            r2_s     <= r1_s;
            r2_g2    <= 40'(gs >> FracBits);
            r2_b2s   <= r1_b2s;
        end
    end

    // stage 3: second moment and bias correction partial products
    logic signed [25:0] c2;
    logic signed [42:0] r3_p2h;
    logic signed [50:0] r3_p2l;
    logic signed [48:0] r3_pvh;
    logic signed [56:0] r3_pvl;
    logic signed [31:0] r3_w, r3_g, r3_vnew;
    logic signed [34:0] r3_decay;
    logic        [30:0] r3_s;
    logic        [55:0] r3_b2s;

    assign c2 = 26'sh1000000 - $signed({1'b0, i_cfg.b2});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_p2h   <= c2 * $signed({1'b0, r2_g2[39:24]});
            r3_p2l   <= c2 * $signed({1'b0, r2_g2[23:0]});
            r3_pvh   <= r2_vnew * $signed({1'b0, i_cfg.inv1[39:24]});
            r3_pvl   <= r2_vnew * $signed({1'b0, i_cfg.inv1[23:0]});
            r3_w     <= r2_w;
            r3_g     <= r2_g;
            r3_vnew  <= r2_vnew;
            r3_decay <= r2_decay;
            r3_s     <= r2_s;
            r3_b2s   <= r2_b2s;
        end
    end

    // stage 4: second moment sum, corrected first moment
    logic signed [69:0] ssum, sr;
    logic signed [56:0] pvr;
    logic signed [49:0] vcs;
    t_carry             n_c4, r4_c;

    assign ssum = $signed({14'b0, r3_b2s}) + (70'(r3_p2h) <<< FracBits) + 70'(r3_p2l);
    assign sr   = (ssum + 70'(Half)) >>> FracBits;
    assign pvr  = (r3_pvl + 57'(Half)) >>> FracBits;
    assign vcs  = 50'(r3_pvh) + 50'(pvr);

    always_comb begin
        n_c4        = '0;
        n_c4.w      = r3_w;
        n_c4.g      = r3_g;
        n_c4.decay  = r3_decay;
        n_c4.vnew   = r3_vnew;
        n_c4.snew   = (i_cfg.mode == MODE_ADAM) ? sat_m(64'(sr)) : r3_s;
        n_c4.vc_neg = vcs[49];
        n_c4.vc_mag = vcs[49] ? 49'(-vcs) : 49'(vcs);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_c <= n_c4;
        end
    end

    // stage 5: bias correction of second moment
    logic [46:0] r5_psh;
    logic [54:0] r5_psl;
    t_carry      r5_c;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_psh <= r4_c.snew * i_cfg.inv2[39:24];
            r5_psl <= r4_c.snew * i_cfg.inv2[23:0];
            r5_c   <= r4_c;
        end
    end

    // stage 6: corrected second moment
    logic [54:0] psr;
    logic [47:0] r6_x;
    t_carry      r6_c;

    assign psr = (r5_psl + 55'd8388608) >> FracBits;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_x <= 48'(r5_psh) + 48'(psr);
            r6_c <= r5_c;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[4:0], i_valid};
        end
    end

    assign o_valid = r_valid[5];
    assign o_carry = r6_c;
    assign o_x     = r6_x;

endmodule

### src/npo_root_cell.sv
module npo_root_cell import npo_pkg::*; #(
    parameter int K = 0
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  logic     i_valid,
    input  t_carry   i_carry,
    input  t_root_st i_st,
    output logic     o_valid,
    output t_carry   o_carry,
    output t_root_st o_st
);

    logic [1:0]  pair;
    logic [39:0] rem2, trial;
    logic        ge;
    t_root_st    n_st, r_st;
    t_carry      r_carry;
    logic        r_valid;

    // next bit pair of the radicand, zeros below the binary point
    generate
        if (2 * K >= FracBits) begin : g_pair
            assign pair = i_st.x[2 * K - FracBits +: 2];
        end else begin : g_zero
            assign pair = 2'b00;
        end
    endgenerate

    // one restoring square root step
    assign rem2  = {i_st.rem, pair};
    assign trial = {2'b00, i_st.root, 2'b01};
    assign ge    = rem2 >= trial;

    always_comb begin
        n_st      = i_st;
        n_st.rem  = ge ? 38'(rem2 - trial) : rem2[37:0];
        n_st.root = {i_st.root[34:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st    <= n_st;
            r_carry <= i_carry;
        end
    end

    assign o_valid = r_valid;
    assign o_carry = r_carry;
    assign o_st    = r_st;

endmodule

### src/npo_div_cell.sv
module npo_div_cell import npo_pkg::*; #(
    parameter int K = 0
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  logic    i_valid,
    input  t_carry  i_carry,
    input  t_div_st i_st,
    output logic    o_valid,
    output t_carry  o_carry,
    output t_div_st o_st
);

    logic        nbit;
    logic [37:0] rem2, den;
    logic        ge;
    t_div_st     n_st, r_st;
    t_carry      r_carry;
    logic        r_valid;

    // dividend bit: magnitude shifted up by the fraction width
    generate
        if (K >= FracBits) begin : g_bit
            assign nbit = i_carry.vc_mag[K - FracBits];
        end else begin : g_zero
            assign nbit = 1'b0;
        end
    endgenerate

    // one restoring division step
    assign rem2 = {i_st.rem, nbit};
    assign den  = {1'b0, i_st.den};
    assign ge   = rem2 >= den;

    always_comb begin
        n_st     = i_st;
        n_st.rem = ge ? 37'(rem2 - den) : rem2[36:0];
        n_st.quo = {i_st.quo[35:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st    <= n_st;
            r_carry <= i_carry;
        end
    end

    assign o_valid = r_valid;
    assign o_carry = r_carry;
    assign o_st    = r_st;

endmodule
